>>> rtl/core/npoc_pkg.sv
// ----------------------------------------------------------------------------
// Non-overlapping pattern occurrence counter package
// Shared widths, register indexes and the control bundle that is broadcast
// to every cell of the counting chain.
// ----------------------------------------------------------------------------
package npoc_pkg;

    // Default number of pattern positions (cells in the chain).
    localparam int MAX_PATTERN_DEF = 8;

    // Field widths.
    localparam int SYM_W     = 8;
    localparam int PSYM_W    = 64;
    localparam int PLEN_W    = 4;
    localparam int COUNT_W   = 17;
    localparam int TOTAL_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 64;

    // Number of pattern symbols held by the pattern register.
    localparam int PSYM_SLOTS = PSYM_W / SYM_W;

    // Saturation limits.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Shortest pattern the block works with.
    localparam int MIN_LENGTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SYMBOLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = 1'b1;

    // Per-transaction control broadcast along the chain.
    typedef struct packed {
        logic             step;
        logic             start;
        logic [SYM_W-1:0] symbol;
    } cell_ctrl_t;

endpackage

>>> rtl/core/npoc_cell.sv
// ----------------------------------------------------------------------------
// Pattern position cell
// Holds the count of one pattern position. The count flows up the chain to
// the next position, and a claim flag flows down so that only the highest
// qualifying position increments.
// ----------------------------------------------------------------------------
module npoc_cell
    import npoc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [SYM_W-1:0]   pat_sym,
    input  logic               active,
    input  logic               is_last,
    input  logic [COUNT_W-1:0] prev_count,
    input  logic               claim_in,
    output logic [COUNT_W-1:0] count_out,
    output logic               claim_out,
    output logic               inc,
    output logic               hit_last
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_eff;
    logic               qualify;

    // A sequence start clears the count before the symbol is handled.
    assign count_eff = ctrl.start ? '0 : count_reg;

    // The position qualifies when its symbol matches and it lags its predecessor.
    assign qualify   = active && (ctrl.symbol == pat_sym) && (count_eff < prev_count);
    assign inc       = qualify && !claim_in;
    assign claim_out = claim_in || qualify;
    assign hit_last  = inc && is_last;
    assign count_out = count_eff;

    assign count_next = inc ? count_eff + COUNT_W'(1) : count_eff;

    // Count register, updated once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.step)
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/nonoverlap_pattern_occurrence_counter.sv
// ----------------------------------------------------------------------------
// Non-overlapping pattern occurrence counter
// A result is registered into the output register, or into the skid entry while the output is stalled.
// Throughput: one symbol per cycle while in_ready is high; the whole cell chain updates together.
// A two-entry output buffer lets input keep flowing while one result waits.
// Reset clears all position counts, the running total and the output buffer,
// and loads the pattern symbols with zero and the pattern length with two.
// ----------------------------------------------------------------------------
module nonoverlap_pattern_occurrence_counter
    import npoc_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SYM_W-1:0]     symbol,
    input  logic                 sequence_start,
    input  logic                 clear_total,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 occurrence_done,
    output logic [TOTAL_W-1:0]   occurrence_total
);

    localparam int LEN_W = ($clog2(MAX_PATTERN + 1) > PLEN_W) ?
                           $clog2(MAX_PATTERN + 1) : PLEN_W;

    logic [PSYM_W-1:0]  pattern_symbols_reg;
    logic [PLEN_W-1:0]  pattern_length_reg;
    logic [LEN_W-1:0]   len_raw;
    logic [LEN_W-1:0]   len_eff;

    cell_ctrl_t         ctrl;
    logic               in_fire;

    logic [COUNT_W-1:0] count_chain [MAX_PATTERN+1];
    logic [MAX_PATTERN:0] claim_chain;
    logic [MAX_PATTERN-1:0] inc_vec;
    logic [MAX_PATTERN-1:0] hit_vec;

    logic               done;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [TOTAL_W-1:0] total_eff;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_done_reg;
    logic               out_done_next;
    logic [TOTAL_W-1:0] out_total_reg;
    logic [TOTAL_W-1:0] out_total_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic               skid_done_reg;
    logic               skid_done_next;
    logic [TOTAL_W-1:0] skid_total_reg;
    logic [TOTAL_W-1:0] skid_total_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_symbols_reg <= '0;
            pattern_length_reg  <= PLEN_W'(MIN_LENGTH);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_SYMBOLS: pattern_symbols_reg <= cfg_data;
                CFG_PATTERN_LENGTH:  pattern_length_reg  <= cfg_data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the pattern length into the supported range.
    assign len_raw = LEN_W'(pattern_length_reg);
    always_comb
    begin
        if (len_raw < LEN_W'(MIN_LENGTH))
        begin
            len_eff = LEN_W'(MIN_LENGTH);
        end
        else if (len_raw > LEN_W'(MAX_PATTERN))
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = len_raw;
        end
    end

    // Input handshake; the buffer only refuses input when both entries are full.
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    assign ctrl.step   = in_fire;
    assign ctrl.start  = sequence_start;
    assign ctrl.symbol = symbol;

    // The first cell compares against the saturation limit, so it saturates.
    assign count_chain[0]           = COUNT_MAX;
    assign claim_chain[MAX_PATTERN] = 1'b0;

    // Chain of position cells.
    for (genvar m = 0; m < MAX_PATTERN; m++)
    begin : g_cell
        logic [SYM_W-1:0] pat_sym;
        logic             active;
        logic             is_last;

        if (m < PSYM_SLOTS)
        begin : g_sym
            assign pat_sym = pattern_symbols_reg[SYM_W*m +: SYM_W];
        end
        else
        begin : g_zero
            assign pat_sym = '0;
        end

        if (m == 0)
        begin : g_first
            assign active  = 1'b1;
            assign is_last = 1'b0;
        end
        else
        begin : g_rest
            assign active  = LEN_W'(m) < len_eff;
            assign is_last = LEN_W'(m) == (len_eff - LEN_W'(1));
        end

        npoc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .pat_sym    (pat_sym),
            .active     (active),
            .is_last    (is_last),
            .prev_count (count_chain[m]),
            .claim_in   (claim_chain[m+1]),
            .count_out  (count_chain[m+1]),
            .claim_out  (claim_chain[m]),
            .inc        (inc_vec[m]),
            .hit_last   (hit_vec[m])
        );
    end

    // Running total with saturation.
    assign done       = |hit_vec;
    assign total_eff  = clear_total ? '0 : total_reg;
    assign total_next = (done && (total_eff != TOTAL_MAX)) ? total_eff + TOTAL_W'(1)
                                                           : total_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (in_fire)
        begin
            total_reg <= total_next;
        end
    end

    // Output register with a skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_done_next   = out_done_reg;
        out_total_next  = out_total_reg;
        skid_valid_next = skid_valid_reg;
        skid_done_next  = skid_done_reg;
        skid_total_next = skid_total_reg;

        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_done_next   = skid_done_reg;
                out_total_next  = skid_total_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                out_done_next  = done;
                out_total_next = total_next;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_done_next  = done;
            skid_total_next = total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_done_reg   <= out_done_next;
        out_total_reg  <= out_total_next;
        skid_done_reg  <= skid_done_next;
        skid_total_reg <= skid_total_next;
    end

    assign out_valid        = out_valid_reg;
    assign occurrence_done  = out_done_reg;
    assign occurrence_total = out_total_reg;

    // At most one position increments per symbol.
    a_one_increment: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(inc_vec))
        else $error("more than one position incremented");

    // The claim leaving the bottom of the chain matches any increment.
    a_claim_matches: assert property (@(posedge clk) disable iff (!rst_n)
        claim_chain[0] == (|inc_vec))
        else $error("claim chain disagrees with increments");

    // The skid entry is only used behind a full output register.
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // A completed occurrence always leaves a nonzero total.
    a_done_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && occurrence_done) |-> (occurrence_total != '0))
        else $error("occurrence reported with zero total");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Non-overlapping pattern occurrence counter testbench
// Sends directed and random symbol sequences through the valid/ready
// channels, with random source gaps and sink stalls. A scoreboard tracks the
// per-position counts and the running total, and checks every result field
// by field in arrival order.
// ----------------------------------------------------------------------------
import npoc_pkg::*;

typedef struct {
    bit               done;
    bit [TOTAL_W-1:0] total;
} occurrence_t;

class occurrence_scoreboard;
    bit [PSYM_W-1:0]  pattern = '0;
    bit [PLEN_W-1:0]  length_code = PLEN_W'(MIN_LENGTH);
    bit [COUNT_W-1:0] counts [MAX_PATTERN_DEF];
    bit [TOTAL_W-1:0] total = '0;
    occurrence_t      expected_occurrences [$];
    int               errors = 0;

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        if (idx == CFG_PATTERN_SYMBOLS)
            pattern = data;
        else
            length_code = data[PLEN_W-1:0];
    endfunction

    function bit [SYM_W-1:0] pattern_symbol(int unsigned pos);
        if (pos >= PSYM_SLOTS)
            return '0;
        return pattern[SYM_W*pos +: SYM_W];
    endfunction

    // Advance the counting chain by one accepted symbol and queue its result.
    function void count_symbol(bit [SYM_W-1:0] sym, bit start, bit clr);
        int unsigned span;
        int unsigned hit;
        occurrence_t res;
        span = 32'(length_code);
        if (span < MIN_LENGTH)
            span = MIN_LENGTH;
        if (span > MAX_PATTERN_DEF)
            span = MAX_PATTERN_DEF;
        if (start)
            foreach (counts[i])
                counts[i] = '0;
        if (clr)
            total = '0;

        // The highest matching position that still trails its predecessor wins.
        hit = 0;
        for (int m = span - 1; m > 0 && hit == 0; m--)
        begin
            if (sym == pattern_symbol(m) && counts[m] < counts[m-1])
            begin
                counts[m] = counts[m] + COUNT_W'(1);
                hit = m;
            end
        end
        if (hit == 0 && sym == pattern_symbol(0) && counts[0] != COUNT_MAX)
            counts[0] = counts[0] + COUNT_W'(1);

        // Advancing the last position completes one occurrence.
        res.done = (hit == span - 1);
        if (res.done && total != TOTAL_MAX)
            total = total + TOTAL_W'(1);
        res.total = total;
        expected_occurrences = {expected_occurrences, res};
    endfunction

    function void check_result(logic done, logic [TOTAL_W-1:0] tot);
        occurrence_t want;
        if (expected_occurrences.size() == 0)
        begin
            $display("%0t: result with nothing expected: done=%0b total=%0d",
                     $time, done, tot);
            errors++;
            return;
        end
        want = expected_occurrences.pop_front();
        if (done !== want.done)
        begin
            $display("%0t: occurrence_done expected %0b, actual %0b",
                     $time, want.done, done);
            errors++;
        end
        if (tot !== want.total)
        begin
            $display("%0t: occurrence_total expected %0d, actual %0d",
                     $time, want.total, tot);
            errors++;
        end
    endfunction

    function int pending();
        return expected_occurrences.size();
    endfunction
endclass

module tb;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [PSYM_W-1:0] DIRECTED_PATTERN = 64'h00FF_5AA5_C33C_01FF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [SYM_W-1:0]     symbol = '0;
    logic                 sequence_start = 1'b0;
    logic                 clear_total = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 occurrence_done;
    logic [TOTAL_W-1:0]   occurrence_total;

    bit steady_source = 1'b0;
    bit steady_sink = 1'b0;
    int idle_cycles = 0;
    int length_codes [12] = '{2, 8, 0, 15, 5, 9, 1, 3, 6, 7, 4, 8};

    occurrence_scoreboard tally = new;

    nonoverlap_pattern_occurrence_counter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .symbol           (symbol),
        .sequence_start   (sequence_start),
        .clear_total      (clear_total),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .occurrence_done  (occurrence_done),
        .occurrence_total (occurrence_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transaction monitor and watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            tally.count_symbol(symbol, sequence_start, clear_total);
        if (rst_n && out_valid && out_ready)
            tally.check_result(occurrence_done, occurrence_total);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("nonoverlap_pattern_occurrence_counter: mismatch");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned effective_span(int unsigned code);
        if (code < MIN_LENGTH)
            return MIN_LENGTH;
        if (code > MAX_PATTERN_DEF)
            return MAX_PATTERN_DEF;
        return code;
    endfunction

    function automatic bit [PSYM_W-1:0] make_pattern();
        bit [SYM_W-1:0]  letters [3];
        bit [SYM_W-1:0]  one;
        bit [PSYM_W-1:0] pat;
        pat = '0;
        case ($urandom_range(0, 3))
            0: pat = {$urandom, $urandom};
            1:
            begin
                // Few distinct letters, so repeated symbols are common.
                foreach (letters[i])
                    letters[i] = SYM_W'($urandom_range(0, 255));
                for (int k = 0; k < PSYM_SLOTS; k++)
                    pat[SYM_W*k +: SYM_W] = letters[$urandom_range(0, 2)];
            end
            2:
            begin
                for (int k = 0; k < PSYM_SLOTS; k++)
                    pat[SYM_W*k +: SYM_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            default:
            begin
                one = SYM_W'($urandom_range(0, 255));
                pat = {PSYM_SLOTS{one}};
            end
        endcase
        return pat;
    endfunction

    // Sink side: ready runs broken by random stalls unless held steady.
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            stall = gap_len();
            if (!steady_sink && stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    task automatic send_item(input bit [SYM_W-1:0] sym, input bit start, input bit clr);
        int gap;
        gap = steady_source ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        symbol         <= sym;
        sequence_start <= start;
        clear_total    <= clr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result, plus the latency.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tally.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        tally.load_register(idx, data);
        @(posedge clk);
    endtask

    // Length writes carry random upper bits, which the block must ignore.
    task automatic write_length(input int unsigned code);
        logic [CFG_W-1:0] data;
        data = {$urandom, $urandom};
        data[PLEN_W-1:0] = PLEN_W'(code);
        write_reg(CFG_PATTERN_LENGTH, data);
    endtask

    task automatic configure(input bit [PSYM_W-1:0] pat, input int unsigned code);
        drain();
        write_reg(CFG_PATTERN_SYMBOLS, pat);
        write_length(code);
    endtask

    // Random sequences that mostly walk through the pattern in order.
    task automatic stream_phase(input bit [PSYM_W-1:0] pat, input int unsigned code,
                                input int quota);
        int          sent;
        int          seq_len;
        int unsigned span;
        int unsigned cursor;
        int          pick;
        bit          start;
        bit [SYM_W-1:0] sym;
        sent = 0;
        span = effective_span(code);
        while (sent < quota)
        begin
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 40);
            cursor = 0;
            for (int i = 0; i < seq_len; i++)
            begin
                // Occasionally change the length in the middle of a sequence.
                if (i > 0 && i == seq_len / 2 && $urandom_range(0, 14) == 0)
                begin
                    drain();
                    code = $urandom_range(0, 15);
                    write_length(code);
                    span = effective_span(code);
                    cursor = 0;
                end
                if (i == 0)
                    start = ($urandom_range(0, 29) != 0);
                else
                    start = ($urandom_range(0, 49) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    sym = pat[SYM_W*cursor +: SYM_W];
                    cursor = (cursor + 1) % span;
                end
                else if (pick < 80)
                    sym = pat[SYM_W*$urandom_range(0, span - 1) +: SYM_W];
                else
                    sym = SYM_W'($urandom_range(0, 255));
                send_item(sym, start, $urandom_range(0, 49) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        bit [PSYM_W-1:0] pat;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pattern: two zero symbols.
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);

        // Full-length pattern with both extreme symbol values.
        configure(DIRECTED_PATTERN, 8);
        for (int k = 0; k < PSYM_SLOTS; k++)
            send_item(DIRECTED_PATTERN[SYM_W*k +: SYM_W], k == 0, 1'b0);
        // Both clears on the same symbol.
        send_item(8'hFF, 1'b1, 1'b1);

        // Lengths below range behave as two.
        drain();
        write_length(0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);
        drain();
        write_length(1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h01, 1'b0, 1'b0);

        // Length above range, changed within the running sequence.
        drain();
        write_length(15);
        for (int k = 2; k < PSYM_SLOTS; k++)
            send_item(DIRECTED_PATTERN[SYM_W*k +: SYM_W], 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // Build up the first position count, then complete a few occurrences.
        configure(64'h0000_0000_0000_A377, 2);
        steady_source = 1'b1;
        steady_sink = 1'b1;
        send_item(8'h77, 1'b1, 1'b0);
        repeat (40)
            send_item(8'h77, 1'b0, 1'b0);
        repeat (3)
            send_item(8'hA3, 1'b0, 1'b0);
        send_item(8'h77, 1'b0, 1'b0);

        // Random phases across lengths and pattern shapes.
        foreach (length_codes[p])
        begin
            steady_source = ($urandom_range(0, 3) == 0);
            steady_sink = ($urandom_range(0, 3) == 0);
            pat = make_pattern();
            configure(pat, length_codes[p]);
            stream_phase(pat, length_codes[p], 170);
        end

        drain();
        repeat (8) @(posedge clk);
        if (tally.errors == 0 && tally.pending() == 0)
            $display("nonoverlap_pattern_occurrence_counter: match");
        else
            $display("nonoverlap_pattern_occurrence_counter: mismatch");
        $finish;
    end
endmodule

>>> nonoverlap_pattern_occurrence_counter.f
rtl/core/npoc_pkg.sv
rtl/core/npoc_cell.sv
rtl/core/nonoverlap_pattern_occurrence_counter.sv
test/tb.sv
